// ----- sv/jsf32_pkg.sv -----
// Shared types and constants for the small fast generator with range draw.
// Used by the controller, the datapath and the top level; depends on nothing.
package jsf32_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = 5;

    localparam logic [WORD_W-1:0] SEED_CONST = 32'hf1ea5eed;
    localparam logic [WORD_W-1:0] ALL_ONES   = 32'hffffffff;

    // last count of the warmup rounds and of the bit-serial divide
    localparam logic [CNT_W-1:0] WARM_LAST = 5'd19;
    localparam logic [CNT_W-1:0] DIV_LAST  = 5'd31;

    localparam logic [1:0] CMD_RESEED = 2'd0;
    localparam logic [1:0] CMD_RAW    = 2'd1;
    localparam logic [1:0] CMD_RANGE  = 2'd2;

    // what the output register loads
    localparam logic [1:0] OUT_ZERO  = 2'd0;
    localparam logic [1:0] OUT_RAW   = 2'd1;
    localparam logic [1:0] OUT_RANGE = 2'd2;
    localparam logic [1:0] OUT_ERR   = 2'd3;

    typedef struct packed {
        logic       load_seed;
        logic       advance;
        logic       cap_range;
        logic       div_init;
        logic       div_src_x;
        logic       div_step;
        logic       out_load;
        logic [1:0] out_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic in_span_zero;
        logic reject;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- sv/jsf32_datapath.sv -----
// Datapath: state words, seed register, bit-serial remainder unit, output register.
// Depends on jsf32_pkg; driven by jsf32_ctrl through t_dp_cmd.
module jsf32_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  jsf32_pkg::t_dp_cmd       i_cmd,
    output jsf32_pkg::t_dp_sts       o_sts,
    input  logic                     i_cfg_valid,
    input  logic [31:0]              i_seed_value,
    input  logic [31:0]              i_range_low,
    input  logic [31:0]              i_range_high,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [31:0]              o_value,
    output logic                     o_range_error
);
    import jsf32_pkg::*;

    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_a, r_b, r_c, r_d;
    logic [WORD_W-1:0] r_lo, r_span;
    logic [WORD_W-1:0] r_dq, r_dr;
    logic [WORD_W-1:0] r_value;
    logic              r_err;
    logic              r_out_valid;

    logic [WORD_W-1:0] n_e, n_a, n_b, n_c, n_d;
    logic [WORD_W:0]   n_trial;
    logic [WORD_W:0]   n_diff;
    logic [WORD_W-1:0] n_dr;

    // one generator round
    always_comb begin
        n_e = r_a - {r_b[4:0], r_b[31:5]};
        n_a = r_b ^ {r_c[14:0], r_c[31:15]};
        n_b = r_c + r_d;
        n_c = r_d + n_e;
        n_d = n_e + n_a;
    end

    // one restoring divide step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_trial = {r_dr, r_dq[WORD_W-1]};
        n_diff  = n_trial - {1'b0, r_span};
        n_dr    = n_diff[WORD_W] ? n_trial[WORD_W-1:0] : n_diff[WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_valid) begin
            r_seed <= i_seed_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= SEED_CONST;
            r_b <= '0;
            r_c <= '0;
            r_d <= '0;
        end else if (i_cmd.load_seed) begin
            r_a <= SEED_CONST;
            r_b <= r_seed;
            r_c <= r_seed;
            r_d <= r_seed;
        end else if (i_cmd.advance) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_range) begin
            r_lo   <= i_range_low;
            r_span <= i_range_high - i_range_low;
        end
        if (i_cmd.div_init) begin
            r_dq <= i_cmd.div_src_x ? r_d : ALL_ONES;
            r_dr <= '0;
        end else if (i_cmd.div_step) begin
            r_dq <= {r_dq[WORD_W-2:0], 1'b0};
            r_dr <= n_dr;
        end
    end

    // output register: holds the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_kind)
                OUT_ZERO: begin
                    r_value <= '0;
                    r_err   <= 1'b0;
                end
                OUT_RAW: begin
                    r_value <= r_d;
                    r_err   <= 1'b0;
                end
                OUT_RANGE: begin
                    r_value <= r_lo + r_dr;
                    r_err   <= 1'b0;
                end
                OUT_ERR: begin
                    r_value <= '0;
                    r_err   <= 1'b1;
                end
            endcase
        end
    end

    // the remainder of all-ones by span stays in r_dr until the final divide starts
    assign o_sts.in_span_zero = (i_range_high == i_range_low);
    assign o_sts.reject       = (r_d >= ~r_dr);
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_value;
    assign o_range_error = r_err;

endmodule

// ----- sv/jsf32_ctrl.sv -----
// Controller state machine: sequences reseed warmup, rejection loop and divides.
// Depends on jsf32_pkg; drives jsf32_datapath through t_dp_cmd.
module jsf32_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_command,
    input  jsf32_pkg::t_dp_sts       i_sts,
    output jsf32_pkg::t_dp_cmd       o_cmd
);
    import jsf32_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WARM = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_DRAW = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_XMOD = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_kind, n_kind;
    logic             accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_kind  = r_kind;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    unique case (i_command)
                        CMD_RESEED: begin
                            o_cmd.load_seed = 1'b1;
                            n_kind  = OUT_ZERO;
                            n_state = S_WARM;
                        end
                        CMD_RAW: begin
                            o_cmd.advance = 1'b1;
                            n_kind  = OUT_RAW;
                            n_state = S_FIN;
                        end
                        CMD_RANGE: begin
                            if (i_sts.in_span_zero) begin
                                n_kind  = OUT_ERR;
                                n_state = S_FIN;
                            end else begin
                                o_cmd.cap_range = 1'b1;
                                o_cmd.div_init  = 1'b1;
                                n_kind  = OUT_RANGE;
                                n_state = S_REM;
                            end
                        end
                        default: begin
                            n_kind  = OUT_ZERO;
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_WARM: begin
                o_cmd.advance = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == WARM_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_REM: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DRAW;
                end
            end
            S_DRAW: begin
                o_cmd.advance = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                // redraw while the word falls in the biased top slice
                if (i_sts.reject) begin
                    n_state = S_DRAW;
                end else begin
                    o_cmd.div_init  = 1'b1;
                    o_cmd.div_src_x = 1'b1;
                    n_cnt   = '0;
                    n_state = S_XMOD;
                end
            end
            S_XMOD: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = r_kind;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_kind  <= OUT_ZERO;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
        end
    end

endmodule

// ----- sv/jsf32_prng_unbiased_range.sv -----
// Top level of the small fast generator with unbiased range draw.
// Depends on jsf32_pkg, jsf32_ctrl and jsf32_datapath.
//
//   channel | handshake                | payload
//   --------+--------------------------+------------------------------------
//   in      | i_in_valid / o_in_ready  | i_command, i_range_low, i_range_high
//   out     | o_out_valid / i_out_ready| o_value, o_range_error
//   cfg     | i_cfg_valid / o_cfg_ready| i_seed_value
//
// One item at a time: a new item is accepted only in the idle state. Raw draw,
// unused command and zero span go from the accept straight to the output load.
// Reseed runs 20 warmup rounds. Range draw runs the two 32-step passes of the
// bit-serial remainder unit, with one more draw for each rejected draw.
// Reset is synchronous and restores the fixed state
// words and a zero seed. A stalled output holds its result; the next item is
// accepted meanwhile and waits at its final step until the output register frees up.
module jsf32_prng_unbiased_range (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_range_low,
    input  logic [31:0] i_range_high,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_value,
    output logic        o_range_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_seed_value
);
    import jsf32_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    jsf32_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    jsf32_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_seed_value  (i_seed_value),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value),
        .o_range_error (o_range_error)
    );

endmodule

// ----- sv/jsf32_checker.sv -----
// Port-level checks for jsf32_prng_unbiased_range, attached by bind.
// Depends only on the top level's ports.
module jsf32_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_value,
    input logic        o_range_error
);

    // a pending result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transaction completed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> o_value == 32'd0)
        else $error("range error with nonzero value");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // one item in flight: input closes after each accepted transaction
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accept");

endmodule

bind jsf32_prng_unbiased_range jsf32_checker u_jsf32_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_value       (o_value),
    .o_range_error (o_range_error)
);

// ----- sim/jsf32_prng_unbiased_range_test.sv -----
// Self-checking testbench for jsf32_prng_unbiased_range: random handshakes on the input and output channels,
// with an in-bench model of the generator state, reseed, raw draw and rejection range draw.
// Depends on jsf32_pkg and the jsf32_prng_unbiased_range RTL.
`timescale 1ns / 1ps

module jsf32_prng_unbiased_range_test;
    import jsf32_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int TIMEOUT_NS   = 10_000_000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 255;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] low;
        logic [31:0] high;
    } t_item;

    typedef struct packed {
        logic [31:0] value;
        logic        range_error;
    } t_draw;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  in_cmd = CMD_RAW;
    logic [31:0] in_low = '0;
    logic [31:0] in_high = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] out_value;
    logic        out_range_error;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_seed = '0;

    // generator model state and seed register copy
    logic [31:0] st_a = SEED_CONST;
    logic [31:0] st_b = '0;
    logic [31:0] st_c = '0;
    logic [31:0] st_d = '0;
    logic [31:0] seed_reg = '0;

    t_item cmd_q[$];
    t_draw draw_q[$];
    int    in_gap = 0;
    int    out_gap = 0;
    int    err_cnt = 0;
    bit    idle_en = 1'b1;

    jsf32_prng_unbiased_range i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_command     (in_cmd),
        .i_range_low   (in_low),
        .i_range_high  (in_high),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_value       (out_value),
        .o_range_error (out_range_error),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_seed_value  (cfg_seed)
    );

    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // one round: e = a - rotl(b,27); a = b ^ rotl(c,17); b = c + d; c = d + e; d = e + a
    function automatic logic [31:0] jsf_round();
        logic [31:0] e;
        e    = st_a - {st_b[4:0], st_b[31:5]};
        st_a = st_b ^ {st_c[14:0], st_c[31:15]};
        st_b = st_c + st_d;
        st_c = st_d + e;
        st_d = e + st_a;
        return st_d;
    endfunction

    function automatic t_draw predict_draw(input t_item it);
        t_draw       r;
        logic [31:0] span;
        logic [31:0] rem;
        logic [31:0] x;
        r = '0;
        case (it.cmd)
            CMD_RESEED: begin
                st_a = SEED_CONST;
                st_b = seed_reg;
                st_c = seed_reg;
                st_d = seed_reg;
                repeat (int'(WARM_LAST) + 1) void'(jsf_round());
            end
            CMD_RAW: begin
                r.value = jsf_round();
            end
            CMD_RANGE: begin
                span = it.high - it.low;
                if (span == '0) begin
                    r.range_error = 1'b1;
                end else begin
                    rem = ALL_ONES % span;
                    // reject draws in the biased tail
                    do begin
                        x = jsf_round();
                    end while (x >= ALL_ONES - rem);
                    r.value = it.low + x % span;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void report_error(input string msg);
        if (err_cnt < 10) $display("ERROR at %0t: %s", $realtime, msg);
        err_cnt++;
    endfunction

    // input driver
    always @(posedge clk) begin : drive_items
        t_item it;
        bit    hold;
        hold = in_valid && !in_ready;
        if (in_valid && in_ready) begin
            it = '{in_cmd, in_low, in_high};
            draw_q.push_back(predict_draw(it));
            if (idle_en && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 11);
        end
        if (rst_n && !hold) begin
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                it = cmd_q.pop_front();
                in_valid <= 1'b1;
                in_cmd   <= it.cmd;
                in_low   <= it.low;
                in_high  <= it.high;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor and output back-pressure
    always @(posedge clk) begin : check_results
        t_draw want;
        if (rst_n && out_valid && out_ready) begin
            if (draw_q.size() == 0) begin
                report_error($sformatf("unexpected result: value %h range_error %b",
                                       out_value, out_range_error));
            end else begin
                want = draw_q.pop_front();
                if (out_value !== want.value || out_range_error !== want.range_error)
                    report_error($sformatf(
                        "expected value %h range_error %b, got value %h range_error %b",
                        want.value, want.range_error, out_value, out_range_error));
            end
        end
        if (out_gap > 0) begin
            out_gap--;
            out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            out_gap = $urandom_range(0, 10);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic add_item(input logic [1:0] c, input logic [31:0] lo, input logic [31:0] hi);
        cmd_q.push_back('{c, lo, hi});
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || in_valid || draw_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_seed  <= v;
        do @(posedge clk); while (!cfg_ready);
        seed_reg = v;
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [31:0] seed;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [1:0]  c;
        int          pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset state, zero spans, span extremes, wrap, unused command, reseed
        add_item(CMD_RAW, '0, '0);
        add_item(CMD_RAW, 32'hffffffff, 32'hffffffff);
        add_item(CMD_RANGE, 32'h0, 32'h0);
        add_item(CMD_RANGE, 32'hffffffff, 32'hffffffff);
        add_item(CMD_RANGE, 32'h5, 32'h5);
        add_item(CMD_RANGE, 32'h0, 32'h1);
        add_item(CMD_RANGE, 32'hffffffff, 32'h0);
        add_item(CMD_RANGE, 32'h0, 32'hffffffff);
        add_item(CMD_RANGE, 32'h1, 32'h0);
        add_item(CMD_RANGE, 32'h0, 32'h80000000);
        add_item(CMD_RANGE, 32'h0, 32'h80000001);
        add_item(CMD_RANGE, 32'h7fffffff, 32'h0);
        add_item(CMD_RANGE, 32'h90000000, 32'h10000000);
        add_item(CMD_RANGE, 32'hffffffff, 32'h00000009);
        add_item(CMD_RANGE, 32'h12345678, 32'h12345680);
        add_item(CMD_UNUSED, 32'hffffffff, 32'hffffffff);
        add_item(CMD_UNUSED, 32'h0, 32'h0);
        add_item(CMD_RAW, 32'h0, 32'h0);
        add_item(CMD_RESEED, 32'h0, 32'hffffffff);
        add_item(CMD_RAW, 32'h0, 32'h0);
        add_item(CMD_RANGE, 32'h0, 32'ha);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       seed = 32'hffffffff;
                1:       seed = 32'h0;
                2:       seed = 32'h1;
                3:       seed = 32'h80000000;
                default: seed = $urandom;
            endcase
            write_seed(seed);
            @(negedge clk);
            // no idling on either side in the last phase
            if (ph == PHASES - 1) idle_en = 1'b0;
            add_item(CMD_RESEED, $urandom, $urandom);
            for (int n = 1; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 6)       c = CMD_RESEED;
                else if (pick < 9)  c = CMD_UNUSED;
                else if (pick < 45) c = CMD_RAW;
                else                c = CMD_RANGE;
                lo = $urandom;
                case ($urandom_range(0, 7))
                    0, 1:    hi = lo + $urandom_range(1, 20);
                    2:       hi = lo + (32'h1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
                    3:       hi = lo;
                    4:       hi = lo - $urandom_range(1, 1000);
                    default: hi = $urandom;
                endcase
                add_item(c, lo, hi);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (draw_q.size() != 0) report_error("results still outstanding at end of run");
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
